[sv/ttmn_pkg.sv]
// ----------------------------------------------------------------------------
// ttmn_pkg
// Shared types and constants for the tree token mutex node.
// ----------------------------------------------------------------------------
package ttmn_pkg;

  localparam int DEF_QUEUE_DEPTH = 16;
  localparam int DEF_NODE_BITS   = 8;
  localparam int ID_W            = 8;
  localparam int CFG_ADDR_W      = 2;

  localparam logic [CFG_ADDR_W-1:0] CFG_SELF_ID   = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_INIT_HOLD = 2'd1;

  typedef enum logic [1:0] {
    FUNC_LOCAL  = 2'd0,
    FUNC_REMOTE = 2'd1,
    FUNC_TOKEN  = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    ACT_TOKEN    = 2'd0,
    ACT_REQUEST  = 2'd1,
    ACT_ENTER    = 2'd2,
    ACT_OVERFLOW = 2'd3
  } action_t;

  typedef struct packed {
    action_t         action;
    logic [ID_W-1:0] dest_node;
    logic            last;
  } result_t;

  typedef struct packed {
    logic [1:0] num;
    result_t    r0;
    result_t    r1;
  } res_push_t;

endpackage

[sv/ttmn_queue_ram.sv]
// ----------------------------------------------------------------------------
// ttmn_queue_ram
// Pending requester queue storage: one write port, one registered read port.
// ----------------------------------------------------------------------------
module ttmn_queue_ram #(
  parameter int QUEUE_DEPTH = 16,
  parameter int NODE_BITS   = 8,
  localparam int PTR_W      = $clog2(QUEUE_DEPTH)
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [PTR_W-1:0]     waddr,
  input  logic [NODE_BITS-1:0] wdata,
  input  logic                 re,
  input  logic [PTR_W-1:0]     raddr,
  output logic [NODE_BITS-1:0] rdata
);

  logic [NODE_BITS-1:0] mem [QUEUE_DEPTH];
  logic [NODE_BITS-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[sv/ttmn_exec.sv]
// ----------------------------------------------------------------------------
// ttmn_exec
// Event execution: holder, queue pointers and configuration; reads the queue
// front, applies one event and produces up to two results.
// ----------------------------------------------------------------------------
module ttmn_exec import ttmn_pkg::*; #(
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
  parameter int NODE_BITS   = DEF_NODE_BITS,
  localparam int PTR_W      = $clog2(QUEUE_DEPTH),
  localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  accept,
  input  logic [1:0]            in_func,
  input  logic [ID_W-1:0]       in_requester,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [ID_W-1:0]       cfg_wdata,
  output logic                  busy,
  output logic                  q_we,
  output logic [PTR_W-1:0]      q_waddr,
  output logic [NODE_BITS-1:0]  q_wdata,
  output logic                  q_re,
  output logic [PTR_W-1:0]      q_raddr,
  input  logic [NODE_BITS-1:0]  q_rdata,
  output res_push_t             push
);

  logic                 busy_r;
  logic [1:0]           func_r;
  logic [NODE_BITS-1:0] req_r;
  logic [NODE_BITS-1:0] self_r;
  logic [NODE_BITS-1:0] holder_r, holder_nxt;
  logic [PTR_W-1:0]     head_r, head_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;

  logic [PTR_W:0]       tail_sum;
  logic [PTR_W-1:0]     tail, head_inc;
  logic                 full, here;
  logic                 push_req, serve;
  logic [NODE_BITS-1:0] push_id, front;
  logic [CNT_W-1:0]     remain;

  assign full     = count_r == CNT_W'(QUEUE_DEPTH);
  assign here     = holder_r == self_r;
  assign tail_sum = {1'b0, head_r} + (PTR_W + 1)'(count_r);
  assign tail     = (tail_sum >= (PTR_W + 1)'(QUEUE_DEPTH)) ?
                    PTR_W'(tail_sum - (PTR_W + 1)'(QUEUE_DEPTH)) : PTR_W'(tail_sum);
  assign head_inc = (head_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_r + 1'b1;
  assign push_id  = (func_t'(func_r) == FUNC_LOCAL) ? self_r : req_r;

  always_comb begin
    holder_nxt = holder_r;
    head_nxt   = head_r;
    count_nxt  = count_r;
    q_we       = 1'b0;
    q_waddr    = tail;
    q_wdata    = push_id;
    push_req   = 1'b0;
    serve      = 1'b0;
    front      = q_rdata;
    remain     = count_r;
    push       = '{num: 2'd0,
                   r0: '{action: ACT_TOKEN, dest_node: '0, last: 1'b0},
                   r1: '{action: ACT_TOKEN, dest_node: '0, last: 1'b0}};
    if (busy_r) begin
      case (func_t'(func_r))
        FUNC_LOCAL: begin
          if (here) begin
            push.num = 2'd1;
            push.r0  = '{action: ACT_ENTER, dest_node: '0, last: 1'b1};
          end else begin
            push_req = 1'b1;
          end
        end
        FUNC_REMOTE: push_req = 1'b1;
        FUNC_TOKEN: begin
          holder_nxt = self_r;
          if (count_r != '0) begin
            if (q_rdata == self_r) begin
              head_nxt  = head_inc;
              count_nxt = count_r - 1'b1;
              push.num  = 2'd1;
              push.r0   = '{action: ACT_ENTER, dest_node: '0, last: 1'b1};
            end else begin
              serve  = 1'b1;
              remain = count_r - 1'b1;
            end
          end
        end
        default: ;
      endcase

      if (push_req) begin
        if (full) begin
          push.num = 2'd1;
          push.r0  = '{action: ACT_OVERFLOW, dest_node: '0, last: 1'b1};
        end else begin
          q_we      = 1'b1;
          count_nxt = count_r + 1'b1;
          if (here) begin
            serve  = 1'b1;
            front  = (count_r == '0) ? push_id : q_rdata;
            remain = count_r;
          end else begin
            push.num = 2'd1;
            push.r0  = '{action: ACT_REQUEST, dest_node: ID_W'(holder_r), last: 1'b1};
          end
        end
      end

      if (serve) begin
        holder_nxt = front;
        head_nxt   = head_inc;
        count_nxt  = remain;
        push.r0    = '{action: ACT_TOKEN, dest_node: ID_W'(front), last: 1'b0};
        if (remain != '0) begin
          push.num = 2'd2;
          push.r1  = '{action: ACT_REQUEST, dest_node: ID_W'(front), last: 1'b1};
        end else begin
          push.num     = 2'd1;
          push.r0.last = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      self_r   <= '0;
      holder_r <= '0;
      head_r   <= '0;
      count_r  <= '0;
    end else begin
      busy_r   <= accept;
      holder_r <= holder_nxt;
      head_r   <= head_nxt;
      count_r  <= count_nxt;
      if (cfg_we && cfg_addr == CFG_SELF_ID) begin
        self_r <= NODE_BITS'(cfg_wdata);
      end
      if (cfg_we && cfg_addr == CFG_INIT_HOLD) begin
        holder_r <= NODE_BITS'(cfg_wdata);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      func_r <= in_func;
      req_r  <= NODE_BITS'(in_requester);
    end
  end

  assign busy    = busy_r;
  assign q_re    = accept;
  assign q_raddr = head_r;

endmodule

[sv/ttmn_out_buf.sv]
// ----------------------------------------------------------------------------
// ttmn_out_buf
// Four-entry result buffer; takes up to two results per cycle.
// ----------------------------------------------------------------------------
module ttmn_out_buf import ttmn_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  res_push_t       push,
  output logic            room2,
  output logic            out_valid,
  input  logic            out_ready,
  output result_t         out_res
);

  result_t    ent_r [4];
  logic [1:0] wptr_r, rptr_r;
  logic [2:0] cnt_r;
  logic       pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = cnt_r != 3'd0;
  assign out_res   = ent_r[rptr_r];
  assign room2     = cnt_r <= 3'd2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_r + push.num;
      rptr_r <= rptr_r + {1'b0, pop};
      cnt_r  <= cnt_r + {1'b0, push.num} - {2'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push.num != 2'd0) begin
      ent_r[wptr_r] <= push.r0;
    end
    if (push.num == 2'd2) begin
      ent_r[wptr_r + 2'd1] <= push.r1;
    end
  end

endmodule

[sv/tree_token_mutex_node_unit.sv]
// ----------------------------------------------------------------------------
// tree_token_mutex_node_unit
// An accepted event reads the queue front, then executes, writing up to two
// results into the output buffer; no new event is taken while one executes
// or the buffer lacks room for two. Results drain one per cycle on out_ready.
// Reset clears holder, queue pointers and config; queue RAM is not cleared.
// ----------------------------------------------------------------------------
module tree_token_mutex_node_unit import ttmn_pkg::*; #(
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
  parameter int NODE_BITS   = DEF_NODE_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            in_func,
  input  logic [ID_W-1:0]       in_requester,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [1:0]            out_action,
  output logic [ID_W-1:0]       out_dest_node,
  output logic                  out_last,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [ID_W-1:0]       cfg_wdata
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  logic                 accept, busy, room2;
  logic                 q_we, q_re;
  logic [PTR_W-1:0]     q_waddr, q_raddr;
  logic [NODE_BITS-1:0] q_wdata, q_rdata;
  res_push_t            push;
  result_t              res;

  assign in_ready = !busy && room2;
  assign accept   = in_valid && in_ready;

  ttmn_queue_ram #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .NODE_BITS   (NODE_BITS)
  ) u_ram (
    .clk   (clk),
    .we    (q_we),
    .waddr (q_waddr),
    .wdata (q_wdata),
    .re    (q_re),
    .raddr (q_raddr),
    .rdata (q_rdata)
  );

  ttmn_exec #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .NODE_BITS   (NODE_BITS)
  ) u_exec (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .in_func      (in_func),
    .in_requester (in_requester),
    .cfg_we       (cfg_we),
    .cfg_addr     (cfg_addr),
    .cfg_wdata    (cfg_wdata),
    .busy         (busy),
    .q_we         (q_we),
    .q_waddr      (q_waddr),
    .q_wdata      (q_wdata),
    .q_re         (q_re),
    .q_raddr      (q_raddr),
    .q_rdata      (q_rdata),
    .push         (push)
  );

  ttmn_out_buf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room2     (room2),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (res)
  );

  assign out_action    = res.action;
  assign out_dest_node = res.dest_node;
  assign out_last      = res.last;

endmodule

[verif/tree_token_mutex_node_unit_tb.sv]
// ----------------------------------------------------------------------------
// tree_token_mutex_node_unit_tb
// Self-checking bench for one node of the tree token mutex. A small class
// tracks holder, pending requester FIFO and node id, works out the actions
// each accepted event should produce, and matches them in order against the
// result channel. Directed events cover the corner cases; random events then
// run under several node id / holder settings and three idling patterns.
// ----------------------------------------------------------------------------
module tree_token_mutex_node_unit_tb import ttmn_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_OFF = 4;

  class node_action_board;
    logic [ID_W-1:0] self_id;
    logic [ID_W-1:0] holder;
    logic [ID_W-1:0] waiting_ids [DEF_QUEUE_DEPTH];
    int unsigned head;
    int unsigned count;
    result_t pending_actions[$];
    int unsigned errors;

    function new();
      self_id = '0;
      holder = '0;
      head = 0;
      count = 0;
      errors = 0;
    endfunction

    task report(string msg);
      errors++;
      $display("%0t ns mismatch: %s", $realtime, msg);
    endtask

    function void add(action_t act, logic [ID_W-1:0] dest);
      result_t r;
      r.action = act;
      r.dest_node = dest;
      r.last = 1'b0;
      pending_actions.push_back(r);
    endfunction

    // token goes to the queue front; ask for it back if others still wait
    function void hand_off();
      holder = waiting_ids[head];
      add(ACT_TOKEN, holder);
      head = (head + 1) % DEF_QUEUE_DEPTH;
      count--;
      if (count != 0) add(ACT_REQUEST, holder);
    endfunction

    function void take_request(logic [ID_W-1:0] id);
      if (count >= DEF_QUEUE_DEPTH) begin
        add(ACT_OVERFLOW, '0);
        return;
      end
      waiting_ids[(head + count) % DEF_QUEUE_DEPTH] = id;
      count++;
      if (holder == self_id) hand_off();
      else add(ACT_REQUEST, holder);
    endfunction

    function void apply_event(logic [1:0] func, logic [ID_W-1:0] req);
      int unsigned n_prior;
      n_prior = pending_actions.size();
      case (func)
        FUNC_LOCAL: begin
          if (holder == self_id) add(ACT_ENTER, '0);
          else take_request(self_id);
        end
        FUNC_REMOTE: take_request(req);
        FUNC_TOKEN: begin
          holder = self_id;
          if (count != 0) begin
            if (waiting_ids[head] == self_id) begin
              head = (head + 1) % DEF_QUEUE_DEPTH;
              count--;
              add(ACT_ENTER, '0);
            end else begin
              hand_off();
            end
          end
        end
        default: ;
      endcase
      if (pending_actions.size() > n_prior)
        pending_actions[pending_actions.size() - 1].last = 1'b1;
    endfunction

    task match_action(logic [1:0] act, logic [ID_W-1:0] dest, logic lst);
      result_t exp_r;
      if (pending_actions.size() == 0) begin
        report($sformatf("unexpected result action %0d dest %0h last %0b", act, dest, lst));
        return;
      end
      exp_r = pending_actions.pop_front();
      if (act !== exp_r.action)
        report($sformatf("action %0d, want %0d", act, exp_r.action));
      if (dest !== exp_r.dest_node)
        report($sformatf("dest_node %0h, want %0h", dest, exp_r.dest_node));
      if (lst !== exp_r.last)
        report($sformatf("last %0b, want %0b", lst, exp_r.last));
    endtask
  endclass

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [1:0]            in_func = FUNC_LOCAL;
  logic [ID_W-1:0]       in_requester = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [1:0]            out_action;
  logic [ID_W-1:0]       out_dest_node;
  logic                  out_last;
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = CFG_SELF_ID;
  logic [ID_W-1:0]       cfg_wdata = '0;

  int src_idle_pct = 8;
  int sink_stall_pct = 59;
  int quiet_cycles = 0;
  node_action_board board = new();

  tree_token_mutex_node_unit uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_func      (in_func),
    .in_requester (in_requester),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_action   (out_action),
    .out_dest_node(out_dest_node),
    .out_last     (out_last),
    .cfg_we       (cfg_we),
    .cfg_addr     (cfg_addr),
    .cfg_wdata    (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= sink_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) board.apply_event(in_func, in_requester);
    if (rst_n && out_valid && out_ready)
      board.match_action(out_action, out_dest_node, out_last);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
          $display("tree_token_mutex_node_unit_tb: done, errors");
          $finish;
        end
      end
    end
  end

  task send_event(input logic [1:0] func, input logic [ID_W-1:0] req);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func <= func;
    in_requester <= req;
    do @(posedge clk); while (!in_ready);
  endtask

  // drop valid, wait out every pending action plus the pipeline tail;
  // the first edge lets the last accepted transaction reach the board
  task settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.pending_actions.size() != 0) @(posedge clk);
    repeat (HOLD_OFF) @(posedge clk);
  endtask

  task write_regs(input bit set_self, input logic [ID_W-1:0] self_v,
                  input bit set_hold, input logic [ID_W-1:0] hold_v);
    if (set_self) begin
      cfg_we <= 1'b1;
      cfg_addr <= CFG_SELF_ID;
      cfg_wdata <= self_v;
      @(posedge clk);
      board.self_id = self_v;
    end
    if (set_hold) begin
      cfg_we <= 1'b1;
      cfg_addr <= CFG_INIT_HOLD;
      cfg_wdata <= hold_v;
      @(posedge clk);
      board.holder = hold_v;
    end
    cfg_we <= 1'b0;
  endtask

  task run_traffic(input int n_events);
    int done_n;
    int r;
    bit push_heavy;
    logic [1:0] func;
    logic [ID_W-1:0] id;
    done_n = 0;
    push_heavy = 1'b1;
    while (done_n < n_events) begin
      if (done_n % 40 == 0) push_heavy = 1'($urandom_range(0, 1));
      r = $urandom_range(0, 99);
      if (r < 15) func = FUNC_LOCAL;
      else if (r < (push_heavy ? 70 : 40)) func = FUNC_REMOTE;
      else if (r < 96) func = FUNC_TOKEN;
      else func = FUNC_UNUSED;
      r = $urandom_range(0, 99);
      if (r < 25) id = board.self_id;
      else if (r < 35) id = board.holder;
      else if (r < 45) id = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      else id = ID_W'($urandom);
      send_event(func, id);
      if (func != FUNC_UNUSED) done_n++;
      if ($urandom_range(0, 199) == 0) settle();
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset config: self 0, holder 0 -> token is here
    send_event(FUNC_LOCAL, 8'h00);
    send_event(FUNC_REMOTE, 8'hFF);
    send_event(FUNC_LOCAL, 8'h33);
    send_event(FUNC_REMOTE, 8'h00);
    send_event(FUNC_UNUSED, 8'hAA);
    send_event(FUNC_TOKEN, 8'h55);
    send_event(FUNC_REMOTE, 8'h00);
    send_event(FUNC_TOKEN, 8'h00);
    send_event(FUNC_TOKEN, 8'h00);
    send_event(FUNC_REMOTE, 8'h80);
    // token away: fill the FIFO, then overflow from both request kinds
    for (int i = 0; i <= DEF_QUEUE_DEPTH; i++) send_event(FUNC_REMOTE, ID_W'(i * 29 + 1));
    send_event(FUNC_LOCAL, 8'h00);
    send_event(FUNC_TOKEN, 8'h00);
    settle();

    for (int seg = 0; seg < 6; seg++) begin
      src_idle_pct = (seg < 2) ? 8 : (seg < 4) ? 59 : 0;
      sink_stall_pct <= (seg < 2) ? 59 : (seg < 4) ? 8 : 0;
      case (seg)
        0: write_regs(1'b1, 8'hFF, 1'b1, 8'hFF);
        1: write_regs(1'b1, 8'h00, 1'b1, 8'hFF);
        2: write_regs(1'b1, 8'hFF, 1'b1, 8'h00);
        3: write_regs(1'b1, 8'h5A, 1'b0, 8'h00);
        4: write_regs(1'b1, 8'hA5, 1'b1, 8'h3C);
        default: write_regs(1'b1, ID_W'($urandom), 1'b1, ID_W'($urandom));
      endcase
      run_traffic(215);
      settle();
    end

    if (board.errors == 0)
      $display("tree_token_mutex_node_unit_tb: done, clean");
    else
      $display("tree_token_mutex_node_unit_tb: done, errors");
    $finish;
  end

endmodule
